// ===== sv/rsm_pkg.sv =====
// Package with the transaction types and constants of the 5:6 polyphase resampler.
`timescale 1ns / 1ps
package rsm_pkg;

    typedef struct packed {
        logic               op;
        logic signed [15:0] sample_in;
        logic [6:0]         coef_index;
        logic signed [15:0] coef_value;
    } t_in;

    typedef struct packed {
        logic signed [15:0] sample_out;
        logic               last_of_run;
    } t_out;

    typedef struct packed {
        logic               is_load;
        logic               pre;
        logic               emit;
        logic [2:0]         phase;
        logic [6:0]         index;
        logic signed [15:0] data;
    } t_cmd;

    localparam logic        OP_SAMPLE  = 1'b0;
    localparam logic        OP_LOAD    = 1'b1;
    localparam logic        MODE_UP    = 1'b0;
    localparam logic        MODE_DOWN  = 1'b1;
    localparam int          NPHASES    = 6;
    localparam logic [2:0]  PHASE_ZERO = 3'd0;
    localparam logic [2:0]  PHASE_ONE  = 3'd1;
    localparam logic [2:0]  PHASE_TOP  = 3'd6;
    localparam logic [2:0]  PHASE_DOWN_TOP = 3'd5;
    localparam logic [31:0] ROUND_BIAS = 32'h0000_8000;

endpackage

// ===== sv/rsm_ram.sv =====
// Generic single write port RAM with one registered read port.
`timescale 1ns / 1ps
module rsm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 96
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== sv/rsm_front.sv =====
// Front end: accepts input transactions, tracks phase and mode, and issues commands.
`timescale 1ns / 1ps
module rsm_front #(
    parameter int TAPS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  rsm_pkg::t_in  i_in_data,
    input  logic          i_cfg_we,
    input  logic          i_cfg_wdata,
    input  logic          i_full,
    output logic          o_push,
    output rsm_pkg::t_cmd o_cmd
);
    import rsm_pkg::*;

    localparam int TABLE_SIZE = NPHASES * TAPS;

    logic       r_mode;
    logic [2:0] r_phase;
    logic [2:0] n_phase;
    logic [2:0] w_up_phase;
    logic       w_accept;
    logic       w_index_ok;

    assign o_in_ready = !i_full;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_index_ok = 32'(i_in_data.coef_index) < 32'(TABLE_SIZE);
    assign w_up_phase = (r_phase == PHASE_ZERO) ? 3'd2 : 3'(r_phase + 3'd1);

    always_comb begin
        o_cmd   = '0;
        n_phase = r_phase;
        o_push  = 1'b0;
        if (i_in_data.op == OP_LOAD) begin
            o_cmd.is_load = 1'b1;
            o_cmd.index   = i_in_data.coef_index;
            o_cmd.data    = i_in_data.coef_value;
            o_push        = w_accept && w_index_ok;
        end else begin
            o_cmd.data = i_in_data.sample_in;
            o_push     = w_accept;
            if (r_mode == MODE_UP) begin
                o_cmd.pre   = (r_phase == PHASE_ZERO);
                o_cmd.emit  = 1'b1;
                o_cmd.phase = w_up_phase;
                n_phase     = (w_up_phase == PHASE_TOP) ? PHASE_ZERO : w_up_phase;
            end else begin
                o_cmd.emit  = (r_phase != PHASE_ZERO);
                o_cmd.phase = r_phase;
                n_phase     = (r_phase >= PHASE_DOWN_TOP) ? PHASE_ZERO
                                                          : 3'(r_phase + 3'd1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_UP;
            r_phase <= PHASE_ZERO;
        end else begin
            if (i_cfg_we) begin
                r_mode <= i_cfg_wdata;
            end
            if (w_accept && i_in_data.op == OP_SAMPLE) begin
                r_phase <= n_phase;
            end
        end
    end
endmodule

// ===== sv/rsm_fifo.sv =====
// Two entry command queue between the front end and the filter engine.
`timescale 1ns / 1ps
module rsm_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  rsm_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output rsm_pkg::t_cmd o_head
);
    import rsm_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_head  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push && !o_full) begin
                r_wptr <= !r_wptr;
            end
            if (i_pop && !o_empty) begin
                r_rptr <= !r_rptr;
            end
            r_count <= 2'(r_count + 2'(i_push && !o_full) - 2'(i_pop && !o_empty));
        end
    end
endmodule

// ===== sv/rsm_back.sv =====
// Filter engine: coefficient table, delay line and shared multiply-accumulate.
`timescale 1ns / 1ps
module rsm_back #(
    parameter int TAPS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_empty,
    input  rsm_pkg::t_cmd i_head,
    output logic          o_pop,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output rsm_pkg::t_out o_out_data
);
    import rsm_pkg::*;

    localparam int DEPTH = NPHASES * TAPS;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(TAPS);
    localparam logic [AW-1:0] TAPS_A = AW'(TAPS);
    localparam logic [CW-1:0] CNT_LAST = CW'(TAPS - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SHIFT,
        S_MAC,
        S_DRAIN,
        S_OUT
    } t_state;

    t_state             r_state, n_state;
    logic signed [15:0] r_dl [TAPS];
    logic signed [15:0] n_dl [TAPS];
    logic [AW-1:0]      r_addr, n_addr;
    logic [CW-1:0]      r_cnt, n_cnt;
    logic [31:0]        r_acc, n_acc;
    t_cmd               r_cmd, n_cmd;
    logic               r_last, n_last;
    logic               r_out_valid, n_out_valid;
    t_out               r_out, n_out;

    logic               r_s1_v, r_s1_last;
    logic signed [15:0] r_s1_samp;
    logic               r_s2_v, r_s2_last;
    logic signed [31:0] r_s2_prod;
    logic               w_issue;
    logic [15:0]        w_rdata;
    logic signed [31:0] w_prod;
    logic [31:0]        w_round;
    logic               w_ram_we;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_pop       = (r_state == S_IDLE) && !i_empty;
    assign w_ram_we    = o_pop && i_head.is_load;
    assign w_issue     = (r_state == S_MAC);
    assign w_prod      = r_s1_samp * signed'(w_rdata);
    assign w_round     = r_acc + ROUND_BIAS;

    rsm_ram #(
        .WIDTH(16),
        .DEPTH(DEPTH)
    ) u_coef_ram (
        .i_clk  (i_clk),
        .i_we   (w_ram_we),
        .i_waddr(AW'(i_head.index)),
        .i_wdata(i_head.data),
        .i_raddr(r_addr),
        .o_rdata(w_rdata)
    );

    always_comb begin
        n_state     = r_state;
        n_dl        = r_dl;
        n_addr      = r_addr;
        n_cnt       = r_cnt;
        n_acc       = r_acc;
        n_cmd       = r_cmd;
        n_last      = r_last;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        if (r_s2_v) begin
            n_acc = r_acc + {r_s2_prod[30:0], 1'b0};
        end
        unique case (r_state)
            S_IDLE: begin
                if (!i_empty && !i_head.is_load) begin
                    n_cmd = i_head;
                    if (i_head.pre) begin
                        n_addr  = TAPS_A - AW'(1);
                        n_cnt   = '0;
                        n_acc   = '0;
                        n_last  = 1'b0;
                        n_state = S_MAC;
                    end else begin
                        n_state = S_SHIFT;
                    end
                end
            end
            S_SHIFT: begin
                for (int j = TAPS - 1; j > 0; j--) begin
                    n_dl[j] = r_dl[j-1];
                end
                n_dl[0] = r_cmd.data;
                if (r_cmd.emit) begin
                    n_addr  = AW'(AW'(r_cmd.phase) * TAPS_A - AW'(1));
                    n_cnt   = '0;
                    n_acc   = '0;
                    n_last  = 1'b1;
                    n_state = S_MAC;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_MAC: begin
                for (int j = 0; j < TAPS - 1; j++) begin
                    n_dl[j] = r_dl[j+1];
                end
                n_dl[TAPS-1] = r_dl[0];
                n_addr = r_addr - AW'(1);
                n_cnt  = r_cnt + CW'(1);
                if (r_cnt == CNT_LAST) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (r_s2_v && r_s2_last) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_out_valid) begin
                    n_out_valid       = 1'b1;
                    n_out.sample_out  = w_round[31:16];
                    n_out.last_of_run = r_last;
                    n_state           = r_last ? S_IDLE : S_SHIFT;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            for (int j = 0; j < TAPS; j++) begin
                r_dl[j] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_dl        <= n_dl;
        end
        r_addr <= n_addr;
        r_cnt  <= n_cnt;
        r_acc  <= n_acc;
        r_cmd  <= n_cmd;
        r_last <= n_last;
        r_out  <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
        end else begin
            r_s1_v <= w_issue;
            r_s2_v <= r_s1_v;
        end
        r_s1_samp <= r_dl[0];
        r_s1_last <= (r_cnt == CNT_LAST);
        r_s2_prod <= w_prod;
        r_s2_last <= r_s1_last;
    end
endmodule

// ===== sv/polyphase_resampler_5_6_top.sv =====
// Top level of the 5:6 polyphase resampler.
// Sequence: an idle engine writes a load transaction to the coefficient RAM as it pops it; a sample
// with one result is shifted into the delay line and run through the multiply-accumulate, and output
// valid rises once the products have drained; a sample with two results first gives a pre-shift result.
// The single multiply-accumulate serves one sample at a time; the queue holds new ones meanwhile.
// Synchronous active-low reset clears delay line, phase, mode and queue but not the RAM.
`timescale 1ns / 1ps
module polyphase_resampler_5_6_top #(
    parameter int TAPS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  rsm_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output rsm_pkg::t_out o_out_data,
    input  logic          i_cfg_we,
    input  logic          i_cfg_wdata
);
    import rsm_pkg::*;

    t_cmd w_push_cmd;
    t_cmd w_head;
    logic w_push;
    logic w_full;
    logic w_pop;
    logic w_empty;

    rsm_front #(
        .TAPS(TAPS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_full     (w_full),
        .o_push     (w_push),
        .o_cmd      (w_push_cmd)
    );

    rsm_fifo u_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_push),
        .i_cmd  (w_push_cmd),
        .o_full (w_full),
        .i_pop  (w_pop),
        .o_empty(w_empty),
        .o_head (w_head)
    );

    rsm_back #(
        .TAPS(TAPS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_empty    (w_empty),
        .i_head     (w_head),
        .o_pop      (w_pop),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data)
    );
endmodule

// ===== sv/rsm_checker.sv =====
// Port level assertions for the resampler top level and the bind that attaches them.
`timescale 1ns / 1ps
module rsm_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          o_in_ready,
    input logic          o_out_valid,
    input logic          i_out_ready,
    input rsm_pkg::t_out o_out_data
);
    import rsm_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("Output valid dropped before the transaction completed.");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_out_data))
        else $error("Output payload changed while stalled.");

    a_out_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready |=> !o_out_valid)
        else $error("Two output transactions arrived in consecutive cycles.");

    a_reset_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_ready && !o_out_valid)
        else $error("Block not empty and ready after reset.");
endmodule

bind polyphase_resampler_5_6_top rsm_checker u_rsm_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_in_ready (o_in_ready),
    .o_out_valid(o_out_valid),
    .i_out_ready(i_out_ready),
    .o_out_data (o_out_data)
);

// ===== dv/polyphase_resampler_5_6_top_tb.sv =====
// Self-checking testbench for the 5:6 polyphase resampler top level.
`timescale 1ns / 1ps
module polyphase_resampler_5_6_top_tb;
    import rsm_pkg::*;

    localparam int TAPS          = 16;
    localparam int COEF_ENTRIES  = NPHASES * TAPS;
    localparam int SETTLE_CYCLES = 2 * TAPS + 48;
    localparam int ITEMS_PER_RUN = 48;

    typedef struct packed {
        t_in  item;
        logic typed;
        t_out want;
    } t_dir_row;

    localparam int DIR_ROWS = 17;
    localparam t_dir_row DIRECTED [DIR_ROWS] = '{
        '{'{OP_SAMPLE, 16'sh7FFF, 7'd0,   16'sh0000}, 1'b1, '{16'sh0000, 1'b0}},
        '{'{OP_SAMPLE, 16'sh8000, 7'd0,   16'sh0000}, 1'b0, '{16'sh0000, 1'b0}},
        '{'{OP_SAMPLE, 16'sh0000, 7'd127, 16'shFFFF}, 1'b0, '{16'sh0000, 1'b0}},
        '{'{OP_SAMPLE, 16'shFFFF, 7'd0,   16'sh0000}, 1'b0, '{16'sh0000, 1'b0}},
        '{'{OP_SAMPLE, 16'sh0001, 7'd0,   16'sh0000}, 1'b0, '{16'sh0000, 1'b0}},
        '{'{OP_LOAD,   16'sh0000, 7'd0,   16'sh7FFF}, 1'b0, '{16'sh0000, 1'b0}},
        '{'{OP_LOAD,   16'sh0000, 7'd95,  16'sh8000}, 1'b0, '{16'sh0000, 1'b0}},
        '{'{OP_LOAD,   16'sh0000, 7'd96,  16'sh3039}, 1'b0, '{16'sh0000, 1'b0}},
        '{'{OP_LOAD,   16'sh7FFF, 7'd127, 16'shFFFF}, 1'b0, '{16'sh0000, 1'b0}},
        '{'{OP_LOAD,   16'sh8000, 7'd47,  16'sh0000}, 1'b0, '{16'sh0000, 1'b0}},
        '{'{OP_SAMPLE, 16'sh8000, 7'd0,   16'sh0000}, 1'b0, '{16'sh0000, 1'b0}},
        '{'{OP_SAMPLE, 16'sh7FFF, 7'd0,   16'sh0000}, 1'b0, '{16'sh0000, 1'b0}},
        '{'{OP_SAMPLE, 16'sh8000, 7'd0,   16'sh0000}, 1'b0, '{16'sh0000, 1'b0}},
        '{'{OP_SAMPLE, 16'sh5555, 7'd0,   16'sh0000}, 1'b0, '{16'sh0000, 1'b0}},
        '{'{OP_SAMPLE, 16'shAAAA, 7'd0,   16'sh0000}, 1'b0, '{16'sh0000, 1'b0}},
        '{'{OP_SAMPLE, 16'sh7FFF, 7'd0,   16'sh0000}, 1'b0, '{16'sh0000, 1'b0}},
        '{'{OP_SAMPLE, 16'sh7FFF, 7'd0,   16'sh0000}, 1'b0, '{16'sh0000, 1'b0}}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_ready;
    t_in  i_in_data;
    logic o_out_valid;
    logic i_out_ready;
    t_out o_out_data;
    logic i_cfg_we;
    logic i_cfg_wdata;

    logic signed [15:0] delay_taps [TAPS];
    logic signed [15:0] coef_mem [COEF_ENTRIES];
    int unsigned        cur_phase;
    logic               cur_mode;
    t_out               expected_samples [$];
    int                 mismatch_count;
    int                 send_idle_pct;
    int                 recv_idle_pct;

    polyphase_resampler_5_6_top #(
        .TAPS(TAPS)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic logic signed [15:0] phase_output(int unsigned p);
        logic [31:0]        acc;
        logic signed [31:0] prod;
        acc = '0;
        for (int i = 0; i < TAPS; i++) begin
            prod = delay_taps[i] * coef_mem[p * TAPS - 1 - i];
            acc  = acc + (prod << 1);
        end
        acc = acc + ROUND_BIAS;
        return acc[31:16];
    endfunction

    function automatic void shift_in_sample(logic signed [15:0] s);
        for (int i = TAPS - 1; i > 0; i--) begin
            delay_taps[i] = delay_taps[i - 1];
        end
        delay_taps[0] = s;
    endfunction

    function automatic void predict_resample(t_in it);
        if (it.op == OP_LOAD) begin
            if (it.coef_index < COEF_ENTRIES) begin
                coef_mem[it.coef_index] = it.coef_value;
            end
            return;
        end
        if (cur_mode == MODE_UP) begin
            if (cur_phase == 0) begin
                cur_phase = 1;
                expected_samples.push_back('{phase_output(1), 1'b0});
            end
            shift_in_sample(it.sample_in);
            cur_phase++;
            expected_samples.push_back('{phase_output(cur_phase), 1'b1});
            if (cur_phase >= NPHASES) begin
                cur_phase = 0;
            end
        end else begin
            shift_in_sample(it.sample_in);
            if (cur_phase > 0) begin
                expected_samples.push_back('{phase_output(cur_phase), 1'b1});
            end
            if (cur_phase >= NPHASES - 1) begin
                cur_phase = 0;
            end else begin
                cur_phase++;
            end
        end
    endfunction

    function automatic logic signed [15:0] pick_sample();
        case ($urandom_range(9))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return 16'shFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic signed [15:0] pick_coef();
        case ($urandom_range(7))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic t_in random_item();
        t_in it;
        int  roll;
        roll          = $urandom_range(99);
        it.sample_in  = pick_sample();
        it.coef_index = 7'($urandom_range(COEF_ENTRIES - 1));
        it.coef_value = pick_coef();
        if (roll < 88) begin
            it.op = OP_SAMPLE;
        end else begin
            it.op = OP_LOAD;
            if (roll >= 98) begin
                it.coef_index = 7'($urandom_range(127, COEF_ENTRIES));
            end
        end
        return it;
    endfunction

    task automatic send_item(t_in it, logic typed, t_out want);
        int first;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        forever begin
            @(posedge i_clk);
            if (o_in_ready) begin
                break;
            end
        end
        first = expected_samples.size();
        predict_resample(it);
        if (typed) begin
            expected_samples[first] = want;
        end
        @(negedge i_clk);
    endtask

    task automatic drain_and_settle();
        i_in_valid <= 1'b0;
        while (expected_samples.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic set_mode(logic m);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= m;
        cur_mode = m;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin : check_out
        t_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_samples.size() == 0) begin
                $display("%0t: unexpected transaction, expected none, got %0d last %0b",
                         $time, o_out_data.sample_out, o_out_data.last_of_run);
                mismatch_count++;
            end else begin
                want = expected_samples.pop_front();
                if (o_out_data.sample_out !== want.sample_out) begin
                    $display("%0t: sample_out mismatch, expected %0d, got %0d",
                             $time, want.sample_out, o_out_data.sample_out);
                    mismatch_count++;
                end
                if (o_out_data.last_of_run !== want.last_of_run) begin
                    $display("%0t: last_of_run mismatch, expected %0b, got %0b",
                             $time, want.last_of_run, o_out_data.last_of_run);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        t_in it;
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_in_data      = '0;
        i_out_ready    = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_wdata    = 1'b0;
        mismatch_count = 0;
        send_idle_pct  = 22;
        recv_idle_pct  = 66;
        cur_phase      = 0;
        cur_mode       = MODE_UP;
        for (int i = 0; i < TAPS; i++) begin
            delay_taps[i] = '0;
        end
        for (int i = 0; i < COEF_ENTRIES; i++) begin
            coef_mem[i] = '0;
        end

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        set_mode(MODE_UP);

        for (int i = 0; i < COEF_ENTRIES; i++) begin
            it.op         = OP_LOAD;
            it.sample_in  = 16'($urandom);
            it.coef_index = 7'(i);
            it.coef_value = pick_coef();
            send_item(it, 1'b0, '0);
        end

        for (int r = 0; r < DIR_ROWS; r++) begin
            send_item(DIRECTED[r].item, DIRECTED[r].typed, DIRECTED[r].want);
        end

        for (int run = 0; run < 6; run++) begin
            case (run / 2)
                0: begin
                    send_idle_pct = 22;
                    recv_idle_pct = 66;
                end
                1: begin
                    send_idle_pct = 66;
                    recv_idle_pct = 22;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            drain_and_settle();
            set_mode((run % 2 == 1) ? MODE_DOWN : MODE_UP);
            repeat (ITEMS_PER_RUN) send_item(random_item(), 1'b0, '0);
        end

        drain_and_settle();
        if (mismatch_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
